>>> sv/lpht_pkg.sv
// types and constants used by the linear-probing hash table top level
package lpht_pkg;

  localparam int TableDepth = 256;
  localparam int SlotW      = $clog2(TableDepth);
  localparam int SizeW      = SlotW + 1;
  localparam int KeyW       = 31;
  localparam int MarkW      = 2;
  localparam int EntryW     = KeyW + MarkW;
  localparam int OpW        = 2;
  localparam int StatusW    = 3;

  // modulo unit: dividend padded to whole digits, four bits a cycle
  localparam int DigitW     = 4;
  localparam int DivW       = 32;
  localparam int DivSteps   = DivW / DigitW;
  localparam int DivCntW    = $clog2(DivSteps);

  typedef enum logic [OpW-1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    STAT_INSERTED  = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_FOUND     = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_REMOVED   = 3'd4
  } status_e;

  typedef enum logic [MarkW-1:0] {
    MARK_EMPTY    = 2'd0,
    MARK_REMOVED  = 2'd1,
    MARK_OCCUPIED = 2'd2
  } mark_e;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DIV    = 5'b00010,
    ST_READ   = 5'b00100,
    ST_CHECK  = 5'b01000,
    ST_RESULT = 5'b10000
  } state_e;

endpackage

>>> sv/lpht_ram.sv
// generic single-write, single-read ram with registered read data
module lpht_ram #(
  parameter int Width = 33,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/linear_probe_hash_table.sv
// top level of the linear-probing hash table with its probe sequencer
//
// Open-addressed table of 31-bit keys, one word in, one word out. Each
// operation first reduces the key modulo the active size in a four-bit-per-cycle
// remainder unit, then issues the first slot read and checks one slot per
// cycle against the registered read data of the slot ram, issuing the next
// read in the same cycle; the result then moves to the output register. An
// operation probes from one slot up to table_size slots, and a new input word
// is taken only once the last result has gone to the output register: the
// input is ready again in the cycle after that load. Operation 3 skips the
// remainder unit and the probes and goes straight to the result. A result
// waiting in the output register holds the next operation in its result
// cycle. Slot marks reset to empty through per-slot valid flops, so no
// clearing pass is needed after reset. table_size of 0 acts as 1, above 256
// as 256; writing it does not clear the table and must only happen while the
// block is idle.
module linear_probe_hash_table
  import lpht_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [SizeW-1:0]   cfg_wdata_i,      // table_size
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [31:0]        s_axis_tdata_i,   // [30:0] key
  input  logic [OpW-1:0]     s_axis_tuser_i,   // [1:0] operation
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [7:0]         m_axis_tdata_o,   // [7:0] slot_index
  output logic [StatusW-1:0] m_axis_tuser_o    // [2:0] status
);

  state_e state_q, state_d;

  logic [SizeW-1:0]   size_q;
  logic [SizeW-1:0]   m_size;
  op_e                op_q;
  logic [KeyW-1:0]    key_q;
  logic [DivW-1:0]    div_q;
  logic [DivCntW-1:0] div_cnt_q;
  logic [SlotW-1:0]   rem_q, rem_d;
  logic [SlotW-1:0]   slot_q, slot_next;
  logic [SlotW-1:0]   probe_q;
  logic               last_probe;

  logic [TableDepth-1:0] mark_vld_q;
  logic                  rd_vld_q;
  logic                  rd_en;
  logic [SlotW-1:0]      rd_addr;
  logic [EntryW-1:0]     rd_data;
  logic                  wr_en;
  logic [EntryW-1:0]     wr_data;
  mark_e                 mark_eff;
  logic [KeyW-1:0]       rd_key;

  logic    chk_done;
  logic    chk_wr;
  mark_e   chk_mark;
  status_e chk_status;
  logic [SlotW-1:0] chk_slot;

  status_e          res_status_q;
  logic [SlotW-1:0] res_slot_q;

  logic             out_vld_q;
  status_e          out_status_q;
  logic [SlotW-1:0] out_slot_q;

  logic in_acc;
  logic out_load;

  assign m_size = (size_q == '0) ? SizeW'(1) :
                  (size_q > SizeW'(TableDepth)) ? SizeW'(TableDepth) : size_q;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_load        = (state_q == ST_RESULT) && (!out_vld_q || m_axis_tready_i);

  // remainder of the key by the active size, one digit a cycle
  always_comb begin
    logic [SlotW:0]   t;
    logic [SlotW-1:0] r;
    r = rem_q;
    for (int b = 0; b < DigitW; b++) begin
      t = {r, div_q[DivW-1-b]};
      if (t >= m_size) begin
        t = t - m_size;
      end
      r = t[SlotW-1:0];
    end
    rem_d = r;
  end

  assign last_probe = ({1'b0, probe_q} + SizeW'(1)) == m_size;
  assign slot_next  = (({1'b0, slot_q} + SizeW'(1)) == m_size) ? '0 : slot_q + SlotW'(1);

  // slot ram entry: mark in the low bits, key above
  assign rd_key   = rd_data[MarkW +: KeyW];
  assign mark_eff = rd_vld_q ? mark_e'(rd_data[MarkW-1:0]) : MARK_EMPTY;

  always_comb begin
    chk_done   = 1'b0;
    chk_wr     = 1'b0;
    chk_mark   = MARK_OCCUPIED;
    chk_status = STAT_NOT_FOUND;
    chk_slot   = '0;
    case (op_q)
      OP_INSERT: begin
        if (mark_eff == MARK_EMPTY || mark_eff == MARK_REMOVED) begin
          chk_done   = 1'b1;
          chk_wr     = 1'b1;
          chk_status = STAT_INSERTED;
          chk_slot   = slot_q;
        end else if (last_probe) begin
          chk_done   = 1'b1;
          chk_status = STAT_FULL;
        end
      end
      OP_SEARCH, OP_REMOVE: begin
        if (mark_eff == MARK_EMPTY) begin
          chk_done = 1'b1;
        end else if (mark_eff == MARK_OCCUPIED && rd_key == key_q) begin
          chk_done = 1'b1;
          chk_slot = slot_q;
          if (op_q == OP_REMOVE) begin
            chk_wr     = 1'b1;
            chk_mark   = MARK_REMOVED;
            chk_status = STAT_REMOVED;
          end else begin
            chk_status = STAT_FOUND;
          end
        end else if (last_probe) begin
          chk_done = 1'b1;
        end
      end
      default: begin
        chk_done = 1'b1;
      end
    endcase
  end

  // next read goes out while the current slot is checked
  assign rd_en   = (state_q == ST_READ) || ((state_q == ST_CHECK) && !chk_done);
  assign rd_addr = (state_q == ST_READ) ? slot_q : slot_next;
  assign wr_en   = (state_q == ST_CHECK) && chk_wr;
  assign wr_data = {key_q, chk_mark};

  lpht_ram #(
    .Width (EntryW),
    .Depth (TableDepth)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (slot_q),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = (op_e'(s_axis_tuser_i) == OP_NONE) ? ST_RESULT : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_cnt_q == DivCntW'(DivSteps - 1)) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (chk_done) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      size_q     <= SizeW'(TableDepth);
      mark_vld_q <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
      if (wr_en) begin
        mark_vld_q[slot_q] <= 1'b1;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q         <= op_e'(s_axis_tuser_i);
      key_q        <= s_axis_tdata_i[KeyW-1:0];
      div_q        <= {{(DivW-KeyW){1'b0}}, s_axis_tdata_i[KeyW-1:0]};
      div_cnt_q    <= '0;
      rem_q        <= '0;
      res_status_q <= STAT_NOT_FOUND;
      res_slot_q   <= '0;
    end
    if (state_q == ST_DIV) begin
      div_q     <= div_q << DigitW;
      div_cnt_q <= div_cnt_q + DivCntW'(1);
      rem_q     <= rem_d;
      if (div_cnt_q == DivCntW'(DivSteps - 1)) begin
        slot_q  <= rem_d;
        probe_q <= '0;
      end
    end
    if (rd_en) begin
      rd_vld_q <= mark_vld_q[rd_addr];
    end
    if (state_q == ST_CHECK) begin
      if (chk_done) begin
        res_status_q <= chk_status;
        res_slot_q   <= chk_slot;
      end else begin
        slot_q  <= slot_next;
        probe_q <= probe_q + SlotW'(1);
      end
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_slot_q   <= res_slot_q;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_slot_q;
  assign m_axis_tuser_o  = out_status_q;

  // the probe address never leaves the active part of the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> ({1'b0, rd_addr} < m_size))
    else $error("probe read outside active table");

  // no more probes than slots in use
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHECK) |-> ({1'b0, probe_q} < m_size))
    else $error("probe count beyond table size");

  // the running remainder stays reduced
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> ({1'b0, rem_q} < m_size))
    else $error("remainder not below table size");

  // a slot written ends the operation and reports an update
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> (state_q == ST_RESULT) &&
              (res_status_q == STAT_INSERTED || res_status_q == STAT_REMOVED))
    else $error("slot write without matching result");

  // an unknown operation goes straight to the result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && op_e'(s_axis_tuser_i) == OP_NONE) |=> (state_q == ST_RESULT))
    else $error("unknown operation did not complete at once");

endmodule
